// ===== rtl/jse_pkg.sv =====
// ----------------------------------------------------------------------------
// jse_pkg: shared types and constants of the JSON structure emitter
// Transfer structs, controller/datapath command and status, phase codes,
// opcodes, status codes and the byte tables for brackets and literals.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jse_pkg;

    localparam int RESULT_LIMIT = 35;
    localparam int INDENT_CAP   = (RESULT_LIMIT - 7) / 2;

    localparam logic [3:0] OP_OPEN_OBJ    = 4'd0;
    localparam logic [3:0] OP_OPEN_ARR    = 4'd1;
    localparam logic [3:0] OP_CLOSE_ANY   = 4'd2;
    localparam logic [3:0] OP_CLOSE_ARR   = 4'd3;
    localparam logic [3:0] OP_CLOSE_OBJ   = 4'd4;
    localparam logic [3:0] OP_NULL        = 4'd5;
    localparam logic [3:0] OP_TRUE        = 4'd6;
    localparam logic [3:0] OP_FALSE       = 4'd7;
    localparam logic [3:0] OP_BEGIN_VALUE = 4'd8;
    localparam logic [3:0] OP_BEGIN_KEY   = 4'd9;
    localparam logic [3:0] OP_CONTENT     = 4'd10;

    localparam logic [1:0] STAT_OK          = 2'd0;
    localparam logic [1:0] STAT_INVALID_END = 2'd1;
    localparam logic [1:0] STAT_TOO_DEEP    = 2'd2;

    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;

    localparam logic [31:0] TXT_NULL  = "null";
    localparam logic [31:0] TXT_TRUE  = "true";
    localparam logic [39:0] TXT_FALSE = "false";

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_ERR    = 4'd1,
        PH_COLON  = 4'd2,
        PH_SPACE  = 4'd3,
        PH_COMMA  = 4'd4,
        PH_NL     = 4'd5,
        PH_INDENT = 4'd6,
        PH_BODY   = 4'd7,
        PH_TRAIL  = 4'd8
    } t_phase;

    localparam int NUM_PHASES = 9;

    typedef enum logic [2:0] {
        BODY_LBRACE,
        BODY_LBRACK,
        BODY_RBRACE,
        BODY_RBRACK,
        BODY_NULL,
        BODY_TRUE,
        BODY_FALSE,
        BODY_TEXT
    } t_body;

    typedef struct packed {
        logic [3:0] opcode;
        logic [7:0] text_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [1:0] status;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic   accept;
        logic   emit;
        logic   last;
        t_phase phase;
    } t_ctrl_cmd;

    typedef struct packed {
        logic [NUM_PHASES-1:0] plan_in;
        logic [NUM_PHASES-1:0] plan;
        logic                  indent_done;
        logic                  body_done;
        logic                  out_free;
    } t_dp_status;

    function automatic logic [2:0] body_len(input t_body kind);
        logic [2:0] len;
        case (kind)
            BODY_NULL:  len = 3'd4;
            BODY_TRUE:  len = 3'd4;
            BODY_FALSE: len = 3'd5;
            default:    len = 3'd1;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] text4_char(input logic [31:0] txt, input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = txt[31:24];
            3'd1:    ch = txt[23:16];
            3'd2:    ch = txt[15:8];
            3'd3:    ch = txt[7:0];
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] text5_char(input logic [39:0] txt, input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = txt[39:32];
            3'd1:    ch = txt[31:24];
            3'd2:    ch = txt[23:16];
            3'd3:    ch = txt[15:8];
            3'd4:    ch = txt[7:0];
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] body_char(input t_body kind, input logic [2:0] idx,
                                             input logic [7:0] text);
        logic [7:0] ch;
        case (kind)
            BODY_LBRACE: ch = CH_LBRACE;
            BODY_LBRACK: ch = CH_LBRACK;
            BODY_RBRACE: ch = CH_RBRACE;
            BODY_RBRACK: ch = CH_RBRACK;
            BODY_NULL:   ch = text4_char(TXT_NULL, idx);
            BODY_TRUE:   ch = text4_char(TXT_TRUE, idx);
            BODY_FALSE:  ch = text5_char(TXT_FALSE, idx);
            default:     ch = text;
        endcase
        return ch;
    endfunction

endpackage

// ===== rtl/jse_ctrl.sv =====
// ----------------------------------------------------------------------------
// jse_ctrl: emitter sequencer
// Steps through the planned phases of one item (error, colon, space, comma,
// newline, indentation, body, trailing newline), one output byte per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jse_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  jse_pkg::t_dp_status i_status,
    output jse_pkg::t_ctrl_cmd  o_cmd
);
    import jse_pkg::*;

    t_phase r_phase;
    t_phase n_phase;
    t_phase w_step_next;

    function automatic t_phase next_planned(input logic [NUM_PHASES-1:0] plan,
                                            input t_phase cur);
        t_phase res;
        res = PH_IDLE;
        for (int i = NUM_PHASES - 1; i > 0; i--) begin
            if (i > int'(cur) && plan[i]) begin
                res = t_phase'(4'(i));
            end
        end
        return res;
    endfunction

    always_comb begin
        case (r_phase)
            PH_INDENT: begin
                w_step_next = i_status.indent_done ? next_planned(i_status.plan, r_phase)
                                                   : PH_INDENT;
            end
            PH_BODY: begin
                w_step_next = i_status.body_done ? next_planned(i_status.plan, r_phase)
                                                 : PH_BODY;
            end
            default: begin
                w_step_next = next_planned(i_status.plan, r_phase);
            end
        endcase
    end

    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_IDLE: begin
                if (i_in_valid) begin
                    n_phase = next_planned(i_status.plan_in, PH_IDLE);
                end
            end
            default: begin
                if (i_status.out_free) begin
                    n_phase = w_step_next;
                end
            end
        endcase
    end

    always_comb begin
        o_cmd.phase  = r_phase;
        o_cmd.accept = (r_phase == PH_IDLE) && i_in_valid;
        o_cmd.emit   = (r_phase != PH_IDLE) && i_status.out_free;
        o_cmd.last   = (w_step_next == PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

endmodule

// ===== rtl/jse_dpath.sv =====
// ----------------------------------------------------------------------------
// jse_dpath: emitter datapath
// Nesting stack, key and start flags, mode register, per-item plan, indent
// and body counters, and the output register with its stall handling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jse_dpath #(
    parameter int MAX_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_data,
    input  jse_pkg::t_in_item   i_in_item,
    input  logic                i_out_stall,
    input  jse_pkg::t_ctrl_cmd  i_cmd,
    output jse_pkg::t_dp_status o_status,
    output logic                o_out_valid,
    output jse_pkg::t_out_item  o_out_item
);
    import jse_pkg::*;

    localparam int AW   = $clog2(MAX_DEPTH);
    localparam int NLEV = 2 ** AW;
    localparam logic [AW-1:0] DEPTH_LIMIT = AW'(MAX_DEPTH - 1);
    localparam logic [AW-1:0] DEPTH_ONE   = AW'(1);

    logic            r_compact;
    logic [AW-1:0]   r_depth;
    logic            r_key_pending;
    logic            r_started;
    logic            r_is_obj   [NLEV];
    logic            r_nonempty [NLEV];

    logic [NUM_PHASES-1:0] r_plan;
    logic [1:0]            r_err_code;
    logic [4:0]            r_ind_cnt;
    t_body                 r_body_kind;
    logic [2:0]            r_body_idx;
    logic [2:0]            r_body_len;
    logic [7:0]            r_text;
    logic                  r_out_valid;
    t_out_item             r_out_item;

    logic [AW-1:0]   n_depth;
    logic            n_key_pending;
    logic            n_started;
    logic            n_out_valid;
    t_out_item       n_out_item;

    logic [3:0]      w_op;
    logic [AW-1:0]   w_lvl;
    logic            w_top_obj;
    logic            w_top_ne;
    logic            w_at_root;
    logic            w_is_open;
    logic            w_is_close;
    logic            w_is_lit;
    logic            w_is_sep;
    logic            w_is_content;
    logic            w_err_deep;
    logic            w_err_end;
    logic            w_use_sep;
    logic            w_pretty_sep;
    logic            w_mark_level;
    logic [AW-1:0]   w_sep_depth;
    logic [4:0]      w_sep5;
    logic [3:0]      w_ind_units;
    logic [NUM_PHASES-1:0] w_plan;
    t_body           w_body_kind;
    logic            w_open_ok;
    logic            w_close_ok;

    assign w_op         = i_in_item.opcode;
    assign w_lvl        = r_depth - DEPTH_ONE;
    assign w_top_obj    = r_is_obj[w_lvl];
    assign w_top_ne     = r_nonempty[w_lvl];
    assign w_at_root    = (r_depth == '0);
    assign w_is_open    = (w_op == OP_OPEN_OBJ) || (w_op == OP_OPEN_ARR);
    assign w_is_close   = (w_op == OP_CLOSE_ANY) || (w_op == OP_CLOSE_ARR) ||
                          (w_op == OP_CLOSE_OBJ);
    assign w_is_lit     = (w_op == OP_NULL) || (w_op == OP_TRUE) || (w_op == OP_FALSE);
    assign w_is_sep     = w_is_lit || (w_op == OP_BEGIN_VALUE) || (w_op == OP_BEGIN_KEY);
    assign w_is_content = (w_op == OP_CONTENT);

    assign w_err_deep   = w_is_open && (r_depth >= DEPTH_LIMIT);
    assign w_err_end    = w_is_close && (w_at_root ||
                          ((w_op == OP_CLOSE_ARR) && w_top_obj) ||
                          ((w_op == OP_CLOSE_OBJ) && !w_top_obj));
    assign w_open_ok    = w_is_open && !w_err_deep;
    assign w_close_ok   = w_is_close && !w_err_end;
    assign w_use_sep    = w_open_ok || w_close_ok || w_is_sep;
    assign w_pretty_sep = w_use_sep && !r_key_pending && !r_compact;
    assign w_mark_level = (w_open_ok || w_is_sep) && !r_key_pending && !w_at_root;

    assign w_sep_depth  = w_is_close ? w_lvl : r_depth;
    assign w_sep5       = 5'(w_sep_depth);
    assign w_ind_units  = (w_sep5 > 5'(INDENT_CAP)) ? 4'(INDENT_CAP) : w_sep5[3:0];

    always_comb begin
        w_plan                   = '0;
        w_plan[int'(PH_ERR)]     = w_err_deep || w_err_end;
        w_plan[int'(PH_COLON)]   = w_use_sep && r_key_pending;
        w_plan[int'(PH_SPACE)]   = w_use_sep && r_key_pending && !r_compact;
        w_plan[int'(PH_COMMA)]   = w_use_sep && !r_key_pending && !w_is_close &&
                                   !w_at_root && w_top_ne;
        w_plan[int'(PH_NL)]      = w_pretty_sep && r_started;
        w_plan[int'(PH_INDENT)]  = w_pretty_sep && (w_ind_units != 4'd0);
        w_plan[int'(PH_BODY)]    = w_open_ok || w_close_ok || w_is_lit || w_is_content;
        w_plan[int'(PH_TRAIL)]   = w_close_ok && (r_depth == DEPTH_ONE) && r_started;
    end

    always_comb begin
        case (w_op)
            OP_OPEN_OBJ:  w_body_kind = BODY_LBRACE;
            OP_OPEN_ARR:  w_body_kind = BODY_LBRACK;
            OP_CLOSE_ANY: w_body_kind = w_top_obj ? BODY_RBRACE : BODY_RBRACK;
            OP_CLOSE_ARR: w_body_kind = w_top_obj ? BODY_RBRACE : BODY_RBRACK;
            OP_CLOSE_OBJ: w_body_kind = w_top_obj ? BODY_RBRACE : BODY_RBRACK;
            OP_NULL:      w_body_kind = BODY_NULL;
            OP_TRUE:      w_body_kind = BODY_TRUE;
            OP_FALSE:     w_body_kind = BODY_FALSE;
            default:      w_body_kind = BODY_TEXT;
        endcase
    end

    always_comb begin
        n_depth       = r_depth;
        n_key_pending = r_key_pending;
        n_started     = r_started;
        if (i_cmd.accept) begin
            if (w_open_ok) begin
                n_depth       = r_depth + DEPTH_ONE;
                n_key_pending = 1'b0;
                n_started     = 1'b1;
            end else if (w_close_ok) begin
                n_depth       = w_lvl;
                n_key_pending = 1'b0;
            end else if (w_is_sep) begin
                n_key_pending = (w_op == OP_BEGIN_KEY);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && w_mark_level) begin
            r_nonempty[w_lvl] <= 1'b1;
        end
        if (i_cmd.accept && w_open_ok) begin
            r_is_obj[r_depth]   <= (w_op == OP_OPEN_OBJ);
            r_nonempty[r_depth] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_plan      <= w_plan;
            r_err_code  <= w_err_deep ? STAT_TOO_DEEP : STAT_INVALID_END;
            r_ind_cnt   <= {w_ind_units, 1'b0};
            r_body_kind <= w_body_kind;
            r_body_idx  <= 3'd0;
            r_body_len  <= body_len(w_body_kind);
            r_text      <= i_in_item.text_byte;
        end else if (i_cmd.emit) begin
            if (i_cmd.phase == PH_INDENT) begin
                r_ind_cnt <= r_ind_cnt - 5'd1;
            end
            if (i_cmd.phase == PH_BODY) begin
                r_body_idx <= r_body_idx + 3'd1;
            end
        end
    end

    always_comb begin
        n_out_item.byte_valid = 1'b1;
        n_out_item.status     = STAT_OK;
        n_out_item.last       = i_cmd.last;
        case (i_cmd.phase)
            PH_ERR: begin
                n_out_item.out_byte   = 8'h00;
                n_out_item.byte_valid = 1'b0;
                n_out_item.status     = r_err_code;
            end
            PH_COLON:  n_out_item.out_byte = CH_COLON;
            PH_SPACE:  n_out_item.out_byte = CH_SPACE;
            PH_COMMA:  n_out_item.out_byte = CH_COMMA;
            PH_NL:     n_out_item.out_byte = CH_NL;
            PH_INDENT: n_out_item.out_byte = CH_SPACE;
            PH_BODY:   n_out_item.out_byte = body_char(r_body_kind, r_body_idx, r_text);
            PH_TRAIL:  n_out_item.out_byte = CH_NL;
            default: begin
                n_out_item.out_byte   = 8'h00;
                n_out_item.byte_valid = 1'b0;
            end
        endcase
    end

    assign n_out_valid = i_cmd.emit || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_item <= n_out_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_compact     <= 1'b0;
            r_depth       <= '0;
            r_key_pending <= 1'b0;
            r_started     <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_compact <= i_cfg_data;
            end
            r_depth       <= n_depth;
            r_key_pending <= n_key_pending;
            r_started     <= n_started;
            r_out_valid   <= n_out_valid;
        end
    end

    assign o_status.plan_in     = w_plan;
    assign o_status.plan        = r_plan;
    assign o_status.indent_done = (r_ind_cnt == 5'd1);
    assign o_status.body_done   = (r_body_idx == (r_body_len - 3'd1));
    assign o_status.out_free    = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== rtl/json_structure_emitter.sv =====
// ----------------------------------------------------------------------------
// json_structure_emitter: JSON structure token to text byte emitter
// Timing: an item is taken while the sequencer is idle; its first result is
// registered from its first planned phase. An item with no result stalls nothing.
// Throughput: one output byte per cycle unless the output stalls, set by the emit
// sequencer; the input stalls until an item's last result is emitted.
// Reset (synchronous, active low) clears depth, flags, mode and output valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module json_structure_emitter #(
    parameter int MAX_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  jse_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output jse_pkg::t_out_item o_out_item
);
    import jse_pkg::*;

    t_ctrl_cmd  w_cmd;
    t_dp_status w_status;

    jse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    jse_dpath #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_in_item),
        .i_out_stall (i_out_stall),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (w_cmd.phase != PH_IDLE);

endmodule

// ===== rtl/jse_checker.sv =====
// ----------------------------------------------------------------------------
// jse_checker: port-level checks of the JSON structure emitter
// Watches the top-level ports for output hold, error result shape, busy
// signaling and reset behavior.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jse_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input jse_pkg::t_out_item o_out_item
);
    import jse_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled output transfer changed");

    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status != STAT_OK) |->
            !o_out_item.byte_valid && o_out_item.last && (o_out_item.out_byte == 8'h00))
        else $error("error result malformed");

    a_byte_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.byte_valid |-> (o_out_item.status == STAT_OK))
        else $error("byte result with error status");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.last |-> o_in_stall)
        else $error("input taken before item finished");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind json_structure_emitter jse_checker u_jse_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
